[src/pmsu_pkg.sv]
// ---------------------------------------------------------------------------
// pmsu_pkg
// Shared types, codes and constants for the perspective matrix setup unit.
// ---------------------------------------------------------------------------
`default_nettype none

package pmsu_pkg;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_FOV    = 2'd1,
    ERR_ASPECT = 2'd2,
    ERR_DEPTH  = 2'd3
  } err_t;

  localparam logic [15:0] FOV_LIMIT     = 16'd46080;
  localparam logic [31:0] HALF_DEG_Q38  = 32'd2398762259;
  localparam logic [47:0] Z_ROUND       = 48'd32768;
  localparam int          DIV_QBITS     = 32;
  localparam int          DIV_LAT       = DIV_QBITS + 3;
  localparam int          FIFO_DEPTH    = 4;
  localparam int          FIFO_AW       = 2;

  typedef struct packed {
    err_t               err;
    logic        [31:0] z;
    logic signed [31:0] asp;
    logic signed [31:0] n;
    logic signed [32:0] range;
    logic signed [63:0] prod;
  } item_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [FIFO_AW:0]     count;
  } fifo_stat_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] v;
    v = '0;
    case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      5'd24: v = 34'sd64;
      5'd25: v = 34'sd32;
      5'd26: v = 34'sd16;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[src/pmsu_front.sv]
// ---------------------------------------------------------------------------
// pmsu_front
// Accepts requests, classifies errors and forms angle, range and product.
// ---------------------------------------------------------------------------
`default_nettype none

module pmsu_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic [15:0]         in_fov_degrees,
  input  wire logic signed [31:0]  in_aspect_ratio,
  input  wire logic signed [31:0]  in_near_plane,
  input  wire logic signed [31:0]  in_far_plane,
  input  wire logic                q_full,
  output      logic                push,
  output      pmsu_pkg::item_t     push_item
);

  logic            fv_r, fv_nxt;
  pmsu_pkg::item_t item_r, item_nxt;
  logic            accept;
  logic [47:0]     zsum;

  assign in_stall  = fv_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = fv_r && !q_full;
  assign push_item = item_r;

  always_comb begin
    zsum = 48'(in_fov_degrees) * 48'(pmsu_pkg::HALF_DEG_Q38) + pmsu_pkg::Z_ROUND;
    item_nxt.z     = zsum[47:16];
    item_nxt.asp   = in_aspect_ratio;
    item_nxt.n     = in_near_plane;
    item_nxt.range = 33'(in_far_plane) - 33'(in_near_plane);
    item_nxt.prod  = 64'(in_far_plane) * 64'(in_near_plane);
    if (in_fov_degrees == '0 || in_fov_degrees >= pmsu_pkg::FOV_LIMIT) begin
      item_nxt.err = pmsu_pkg::ERR_FOV;
    end else if (in_aspect_ratio == '0) begin
      item_nxt.err = pmsu_pkg::ERR_ASPECT;
    end else if (in_far_plane == in_near_plane) begin
      item_nxt.err = pmsu_pkg::ERR_DEPTH;
    end else begin
      item_nxt.err = pmsu_pkg::ERR_NONE;
    end
  end

  always_comb begin
    fv_nxt = fv_r;
    if (accept) begin
      fv_nxt = 1'b1;
    end else if (push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

[src/pmsu_fifo.sv]
// ---------------------------------------------------------------------------
// pmsu_fifo
// Short request queue between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module pmsu_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire pmsu_pkg::item_t      push_item,
  input  wire logic                 pop,
  output      pmsu_pkg::item_t      pop_item,
  output      pmsu_pkg::fifo_stat_t stat
);

  pmsu_pkg::item_t                mem [pmsu_pkg::FIFO_DEPTH];
  logic [pmsu_pkg::FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [pmsu_pkg::FIFO_AW:0]     cnt_r, cnt_nxt;

  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == (pmsu_pkg::FIFO_AW+1)'(pmsu_pkg::FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_item   = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[src/pmsu_div.sv]
// ---------------------------------------------------------------------------
// pmsu_div
// Pipelined signed divider, one quotient bit a stage, truncating, saturated.
// ---------------------------------------------------------------------------
`default_nettype none

module pmsu_div #(
  parameter int DW    = 48,
  parameter int VW    = 33,
  parameter int SW    = 1,
  parameter bit NEG_Q = 1'b0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [DW-1:0] dividend,
  input  wire logic signed [VW-1:0] divisor,
  input  wire logic [SW-1:0]        sb_in,
  output      logic signed [31:0]   quot,
  output      logic [SW-1:0]        sb_out
);

  localparam int QB = pmsu_pkg::DIV_QBITS;

  logic [DW-1:0]  md_r;
  logic [VW-1:0]  mv_r;
  logic           n0_r;
  logic [SW-1:0]  s0_r;

  logic [VW-1:0]  rem_r [QB+1];
  logic [QB-1:0]  lo_r  [QB+1];
  logic [QB-1:0]  q_r   [QB+1];
  logic [VW-1:0]  v_r   [QB+1];
  logic           neg_r [QB+1];
  logic           ovf_r [QB+1];
  logic [SW-1:0]  sb_r  [QB+1];

  logic signed [31:0] quot_r;
  logic [SW-1:0]      sbo_r;

  assign quot   = quot_r;
  assign sb_out = sbo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      md_r <= dividend[DW-1] ? $unsigned(-dividend) : $unsigned(dividend);
      mv_r <= divisor[VW-1] ? $unsigned(-divisor) : $unsigned(divisor);
      n0_r <= dividend[DW-1] ^ divisor[VW-1] ^ NEG_Q;
      s0_r <= sb_in;
      rem_r[0] <= VW'(md_r >> QB);
      lo_r[0]  <= md_r[QB-1:0];
      q_r[0]   <= '0;
      v_r[0]   <= mv_r;
      neg_r[0] <= n0_r;
      ovf_r[0] <= (md_r >> QB) >= DW'(mv_r);
      sb_r[0]  <= s0_r;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [VW:0] t;
    logic        ge;
    assign t  = {rem_r[k], lo_r[k][QB-1]};
    assign ge = t >= {1'b0, v_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? VW'(t - {1'b0, v_r[k]}) : VW'(t);
        lo_r[k+1]  <= {lo_r[k][QB-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][QB-2:0], ge};
        v_r[k+1]   <= v_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
        sb_r[k+1]  <= sb_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbo_r <= sb_r[QB];
      if (neg_r[QB]) begin
        if (ovf_r[QB] || q_r[QB] > 32'h8000_0000) begin
          quot_r <= 32'sh8000_0000;
        end else begin
          quot_r <= -$signed(q_r[QB]);
        end
      end else begin
        if (ovf_r[QB] || q_r[QB][31]) begin
          quot_r <= 32'sh7FFF_FFFF;
        end else begin
          quot_r <= $signed(q_r[QB]);
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/pmsu_back.sv]
// ---------------------------------------------------------------------------
// pmsu_back
// CORDIC cotangent pipeline, coefficient dividers and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pmsu_back #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire pmsu_pkg::item_t    q_item,
  output      logic               pop,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic signed [31:0] out_x_scale,
  output      logic signed [31:0] out_y_scale,
  output      logic signed [31:0] out_depth_scale,
  output      logic signed [31:0] out_depth_offset,
  output      logic [1:0]         out_error_code
);

  localparam int CS    = CORDIC_STAGES;
  localparam int TOTAL = CS + 1 + 2 * pmsu_pkg::DIV_LAT;

  typedef struct packed {
    pmsu_pkg::err_t     err;
    logic signed [31:0] asp;
    logic signed [31:0] n;
    logic signed [32:0] range;
    logic signed [63:0] prod;
  } side_t;

  typedef struct packed {
    pmsu_pkg::err_t     err;
    logic signed [31:0] cot;
    logic signed [31:0] ds;
    logic signed [31:0] dofs;
  } coef_t;

  logic                adv;
  logic [TOTAL-1:0]    vld_r;
  logic signed [33:0]  cx_r [CS+1];
  logic signed [33:0]  cy_r [CS+1];
  logic signed [33:0]  cz_r [CS+1];
  side_t               sb_r [CS+1];

  logic signed [31:0]  cot_q, ds_q, dofs_q, xs_q, cot_fix;
  logic                ynp_q;
  logic [1:0]          err_q1;
  logic signed [31:0]  asp_q;
  coef_t               c_in, c_out;

  logic                ov_r;
  logic signed [31:0]  xs_r, ys_r, ds_r, do_r;
  logic [1:0]          ec_r;

  assign adv = !ov_r || !out_stall;
  assign pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ov_r  <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[TOTAL-2:0], pop};
      ov_r  <= vld_r[TOTAL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= 34'sd1 <<< 30;
      cy_r[0] <= '0;
      cz_r[0] <= $signed({2'b00, q_item.z});
      sb_r[0] <= '{err: q_item.err, asp: q_item.asp, n: q_item.n,
                  range: q_item.range, prod: q_item.prod};
    end
  end

  for (genvar s = 0; s < CS; s++) begin : g_cordic
    logic signed [33:0] dx, dy, at;
    assign dx = cy_r[s] >>> s;
    assign dy = cx_r[s] >>> s;
    assign at = pmsu_pkg::atan_q30(5'(s));
    always_ff @(posedge clk) begin
      if (adv) begin
        sb_r[s+1] <= sb_r[s];
        if (!cz_r[s][33]) begin
          cx_r[s+1] <= cx_r[s] - dx;
          cy_r[s+1] <= cy_r[s] + dy;
          cz_r[s+1] <= cz_r[s] - at;
        end else begin
          cx_r[s+1] <= cx_r[s] + dx;
          cy_r[s+1] <= cy_r[s] - dy;
          cz_r[s+1] <= cz_r[s] + at;
        end
      end
    end
  end

  pmsu_div #(.DW(34 + FRAC_BITS), .VW(34), .SW(1), .NEG_Q(1'b0)) u_div_cot (
    .clk      (clk),
    .en       (adv),
    .dividend ($signed({cx_r[CS], {FRAC_BITS{1'b0}}})),
    .divisor  (cy_r[CS]),
    .sb_in    (cy_r[CS] <= 34'sd0),
    .quot     (cot_q),
    .sb_out   (ynp_q)
  );

  pmsu_div #(.DW(32 + FRAC_BITS), .VW(33), .SW(2), .NEG_Q(1'b1)) u_div_ds (
    .clk      (clk),
    .en       (adv),
    .dividend ($signed({sb_r[CS].n, {FRAC_BITS{1'b0}}})),
    .divisor  (sb_r[CS].range),
    .sb_in    (sb_r[CS].err),
    .quot     (ds_q),
    .sb_out   (err_q1)
  );

  pmsu_div #(.DW(64), .VW(33), .SW(32), .NEG_Q(1'b1)) u_div_dofs (
    .clk      (clk),
    .en       (adv),
    .dividend (sb_r[CS].prod),
    .divisor  (sb_r[CS].range),
    .sb_in    (sb_r[CS].asp),
    .quot     (dofs_q),
    .sb_out   (asp_q)
  );

  assign cot_fix = ynp_q ? 32'sh7FFF_FFFF : cot_q;

  always_comb begin
    c_in.err  = pmsu_pkg::err_t'(err_q1);
    c_in.cot  = cot_fix;
    c_in.ds   = ds_q;
    c_in.dofs = dofs_q;
  end

  pmsu_div #(.DW(32 + FRAC_BITS), .VW(32), .SW($bits(coef_t)), .NEG_Q(1'b0)) u_div_xs (
    .clk      (clk),
    .en       (adv),
    .dividend ($signed({cot_fix, {FRAC_BITS{1'b0}}})),
    .divisor  (asp_q),
    .sb_in    (c_in),
    .quot     (xs_q),
    .sb_out   (c_out)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ec_r <= c_out.err;
      if (c_out.err != pmsu_pkg::ERR_NONE) begin
        xs_r <= '0;
        ys_r <= '0;
        ds_r <= '0;
        do_r <= '0;
      end else begin
        xs_r <= xs_q;
        ys_r <= c_out.cot;
        ds_r <= c_out.ds;
        do_r <= c_out.dofs;
      end
    end
  end

  assign out_valid        = ov_r;
  assign out_x_scale      = xs_r;
  assign out_y_scale      = ys_r;
  assign out_depth_scale  = ds_r;
  assign out_depth_offset = do_r;
  assign out_error_code   = ec_r;

endmodule

`default_nettype wire

[src/perspective_matrix_setup_unit.sv]
// ---------------------------------------------------------------------------
// perspective_matrix_setup_unit
// Throughput: one request per cycle unless in_stall or out_stall holds the
// flow; the tangent and divider pipelines are fully unrolled, one CORDIC
// step or one quotient bit per stage.
// Reset: rst_n synchronous, active low; clears queue and valid flags.
// ---------------------------------------------------------------------------
`default_nettype none

module perspective_matrix_setup_unit #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [15:0]        in_fov_degrees,
  input  wire logic signed [31:0] in_aspect_ratio,
  input  wire logic signed [31:0] in_near_plane,
  input  wire logic signed [31:0] in_far_plane,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic signed [31:0] out_x_scale,
  output      logic signed [31:0] out_y_scale,
  output      logic signed [31:0] out_depth_scale,
  output      logic signed [31:0] out_depth_offset,
  output      logic [1:0]         out_error_code
);

  logic                 push, pop;
  pmsu_pkg::item_t      push_item, pop_item;
  pmsu_pkg::fifo_stat_t stat;

  pmsu_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_fov_degrees  (in_fov_degrees),
    .in_aspect_ratio (in_aspect_ratio),
    .in_near_plane   (in_near_plane),
    .in_far_plane    (in_far_plane),
    .q_full          (stat.full),
    .push            (push),
    .push_item       (push_item)
  );

  pmsu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (stat)
  );

  pmsu_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (stat.empty),
    .q_item           (pop_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x_scale      (out_x_scale),
    .out_y_scale      (out_y_scale),
    .out_depth_scale  (out_depth_scale),
    .out_depth_offset (out_depth_offset),
    .out_error_code   (out_error_code)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != pmsu_pkg::ERR_NONE |->
      out_x_scale == '0 && out_y_scale == '0 &&
      out_depth_scale == '0 && out_depth_offset == '0)
    else $error("error result carries nonzero coefficients");

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= ($bits(stat.count))'(pmsu_pkg::FIFO_DEPTH))
    else $error("queue count above depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("push into full queue");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("valid or stall after reset");

endmodule

`default_nettype wire

[tb/perspective_matrix_setup_unit_tb.sv]
// ---------------------------------------------------------------------------
// perspective_matrix_setup_unit_tb
// Self-checking bench for the perspective coefficient unit. Requests carry
// field of view, aspect and clip planes; a local CORDIC and divider model
// predicts every coefficient and error code, results are checked in order.
// ---------------------------------------------------------------------------
`default_nettype none

module perspective_matrix_setup_unit_tb;

  localparam int FRAC = 16;
  localparam int STAGES = 16;
  localparam longint MAX_CYCLES = 400000;

  typedef struct {
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [31:0] ds;
    logic signed [31:0] dofs;
    pmsu_pkg::err_t err;
  } coeff_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [15:0] in_fov_degrees;
  logic signed [31:0] in_aspect_ratio;
  logic signed [31:0] in_near_plane;
  logic signed [31:0] in_far_plane;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_x_scale;
  logic signed [31:0] out_y_scale;
  logic signed [31:0] out_depth_scale;
  logic signed [31:0] out_depth_offset;
  logic [1:0] out_error_code;

  coeff_t coeff_queue[$];
  int mismatches;
  longint cycles;
  bit drain_ok;
  int out_wait;

  perspective_matrix_setup_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_fov_degrees(in_fov_degrees), .in_aspect_ratio(in_aspect_ratio),
    .in_near_plane(in_near_plane), .in_far_plane(in_far_plane),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x_scale(out_x_scale), .out_y_scale(out_y_scale),
    .out_depth_scale(out_depth_scale), .out_depth_offset(out_depth_offset),
    .out_error_code(out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint cot_of_half_fov(input logic [15:0] fov);
    longint x, y, z, dx, dy;
    longint angles[32];
    angles = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0};
    x = 64'sd1 <<< 30;
    y = 0;
    z = longint'((64'(fov) * 64'd2398762259 + 64'd32768) >> 16);
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= angles[i];
      end else begin
        x += dx; y -= dy; z += angles[i];
      end
    end
    if (y <= 0) return 64'sd2147483647;
    return clamp32((x * (64'sd1 <<< FRAC)) / y);
  endfunction

  function automatic coeff_t predict_coeffs(input logic [15:0] fov,
      input logic signed [31:0] asp, input logic signed [31:0] n,
      input logic signed [31:0] f);
    coeff_t c;
    longint cot, rng, ln, lf;
    c = '{0, 0, 0, 0, pmsu_pkg::ERR_NONE};
    ln = n;
    lf = f;
    rng = lf - ln;
    if (fov == 0 || fov >= pmsu_pkg::FOV_LIMIT) c.err = pmsu_pkg::ERR_FOV;
    else if (asp == 0) c.err = pmsu_pkg::ERR_ASPECT;
    else if (rng == 0) c.err = pmsu_pkg::ERR_DEPTH;
    if (c.err != pmsu_pkg::ERR_NONE) return c;
    cot = cot_of_half_fov(fov);
    c.ys = 32'(cot);
    c.xs = 32'(clamp32((cot * (64'sd1 <<< FRAC)) / longint'(asp)));
    c.ds = 32'(clamp32((-ln * (64'sd1 <<< FRAC)) / rng));
    c.dofs = 32'(clamp32(-(lf * ln) / rng));
    return c;
  endfunction

  task automatic send_request(input logic [15:0] fov, input logic [31:0] asp,
      input logic [31:0] n, input logic [31:0] f);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 13));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_fov_degrees <= fov;
    in_aspect_ratio <= asp;
    in_near_plane <= n;
    in_far_plane <= f;
    coeff_queue.push_back(predict_coeffs(fov, asp, n, f));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        coeff_t e;
        if (coeff_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
        end else begin
          e = coeff_queue.pop_front();
          if (out_x_scale !== e.xs || out_y_scale !== e.ys ||
              out_depth_scale !== e.ds || out_depth_offset !== e.dofs ||
              out_error_code !== e.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h %h %0d got %h %h %h %h %0d",
                e.xs, e.ys, e.ds, e.dofs, e.err, out_x_scale, out_y_scale,
                out_depth_scale, out_depth_offset, out_error_code);
          end
        end
        if (drain_ok || $urandom_range(0, 3) == 0) out_wait = 0;
        else out_wait = int'($urandom_range(0, 13));
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_stall <= (out_wait > 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] rand_q(input int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(1, 32'h0010_0000);
      2: return -$urandom_range(1, 32'h0010_0000);
      default: return $urandom_range(0, 32'h0000_4000);
    endcase
  endfunction

  task automatic test_errors();
    send_request(16'd0, 32'h1_0000, 32'h1000, 32'h10_0000);
    send_request(16'd46080, 32'h1_0000, 32'h1000, 32'h10_0000);
    send_request(16'hFFFF, 32'd0, 32'h1000, 32'h1000);
    send_request(16'd23040, 32'd0, 32'h1000, 32'h1000);
    send_request(16'd23040, 32'h1_0000, 32'h1000, 32'h1000);
    send_request(16'd23040, 32'h1_0000, 32'h8000_0000, 32'h8000_0000);
  endtask

  task automatic test_extremes();
    send_request(16'd1, 32'h1_0000, 32'h1000, 32'h10_0000);
    send_request(16'd2, 32'd1, 32'h1000, 32'h10_0000);
    send_request(16'd46079, 32'h1_0000, 32'h1000, 32'h10_0000);
    send_request(16'd46079, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(16'd23040, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(16'd23040, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
    send_request(16'd15360, 32'h1_5555, 32'h0000_1999, 32'h0064_0000);
    send_request(16'd100, 32'h0000_0001, 32'hFFFF_0000, 32'd0);
  endtask

  task automatic test_random();
    logic [15:0] fov;
    logic [31:0] asp, n, f;
    for (int i = 0; i < 1336; i++) begin
      case ($urandom_range(0, 9))
        0: fov = 16'($urandom());
        1: fov = 16'($urandom_range(0, 8));
        2: fov = 16'($urandom_range(46070, 46090));
        default: fov = 16'($urandom_range(1, 46079));
      endcase
      asp = ($urandom_range(0, 30) == 0) ? 32'd0 : rand_q($urandom_range(0, 3));
      n = rand_q($urandom_range(0, 3));
      f = ($urandom_range(0, 30) == 0) ? n : rand_q($urandom_range(0, 3));
      send_request(fov, asp, n, f);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_fov_degrees = '0;
    in_aspect_ratio = '0;
    in_near_plane = '0;
    in_far_plane = '0;
    out_stall = 1'b0;
    mismatches = 0;
    cycles = 0;
    drain_ok = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_errors();
    test_extremes();
    test_random();
    in_valid <= 1'b0;
    while (coeff_queue.size() != 0) @(posedge clk);
    drain_ok = 1'b1;
    repeat (STAGES + 80) @(posedge clk);
    if (mismatches == 0 && coeff_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

`default_nettype wire

[perspective_matrix_setup_unit.f]
src/pmsu_pkg.sv
src/pmsu_front.sv
src/pmsu_fifo.sv
src/pmsu_div.sv
src/pmsu_back.sv
src/perspective_matrix_setup_unit.sv
tb/perspective_matrix_setup_unit_tb.sv
